>>> hw/rtl/scfl_pkg.sv
// ----------------------------------------------------------------------------
// scfl_pkg
// Shared types and constants of the size-class free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package scfl_pkg;

	localparam int ADDR_W     = 16;    // byte address width
	localparam int CFG_W      = 7;     // config register width
	localparam int CFG_IDX_W  = 2;     // config register index width
	localparam int CLS_W      = 5;     // size class code width
	localparam int PG_W       = 13;    // page count arithmetic width
	localparam int LINK_WORDS = 16384; // one next pointer per 4-byte word
	localparam int LINK_AW    = 14;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE_PAGES  = 2'd0,
		CFG_LIMIT_PAGES = 2'd1,
		CFG_GROW_MIN    = 2'd2,
		CFG_GROW_MAX    = 2'd3
	} cfg_reg_t;

	typedef enum logic [0:0] {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_REL,
		ST_GROW,
		ST_COMMIT,
		ST_CARVE,
		ST_FILL,
		ST_POPRD
	} state_t;

	// growth plan: growth needed, current total, pages to add
	typedef struct packed {
		logic            need;
		logic [PG_W-1:0] cur;
		logic [PG_W-1:0] plus;
	} grow_plan_t;

endpackage

`default_nettype wire

>>> hw/rtl/size_class_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// size_class_free_list_allocator_top
// Power-of-two size-class allocator over a paged 16-bit region.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream: tuser is the opcode (allocate / release),
// tdata carries alloc_size and release_addr. Every request yields exactly one
// response on the m_ stream: tdata is block_addr, tuser is out_of_memory.
// Config registers are written through the cfg_ channel (always ready) and
// must only change while no request is in flight.
// Sequencing: an allocation from a non-empty class or a release is answered
// from ST_POP or ST_REL, once the registered read of the link RAM or page tag
// RAM returns. An ignored release is answered straight from idle, a refused
// growth after ST_GROW and ST_COMMIT. An allocation from an empty class carves
// a page; a small class passes ST_FILL, one link word written per cycle.
// One request is in service at a time; a new one is taken while the last
// response is still held in the output register, as long as that is taken.
// Reset empties all class lists, the spare pool and the growth count, and
// loads the config defaults. Link and tag RAMs are not cleared.
// A stalled m_tready simply holds the response; no request is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module size_class_free_list_allocator_top #(
	parameter int PAGE_BITS   = 10,
	parameter int MAX_PAGES   = 64,
	parameter int NUM_CLASSES = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// request stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [31:0]                       s_tdata,   // alloc_size, release_addr
	input  wire logic [0:0]                        s_tuser,   // opcode
	// response stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [15:0]                       m_tdata,   // block_addr
	output logic      [0:0]                        m_tuser,   // out_of_memory
	// config write channel
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [scfl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [scfl_pkg::CFG_W-1:0]        cfg_data
);
	import scfl_pkg::*;

	localparam int CW         = $clog2(NUM_CLASSES);
	localparam int TW         = $clog2(MAX_PAGES);
	localparam int ADDR_PAGES = 1 << (ADDR_W - PAGE_BITS);
	localparam int PAGE_LIM   = (MAX_PAGES < ADDR_PAGES) ? MAX_PAGES : ADDR_PAGES;
	localparam int FILL_W     = PAGE_BITS - 3;

	// config
	logic [CFG_W-1:0] base_pages_q, limit_pages_q, grow_min_q, grow_max_q;

	// allocator state
	logic [ADDR_W-1:0] heads_q [NUM_CLASSES];
	logic [PG_W-1:0]   spare_q, carve_pg_q, grown_q;

	// per-request working registers
	state_t            state_q, state_d;
	logic [CLS_W-1:0]  cls_q;
	logic [ADDR_W-1:0] ptr_q;
	grow_plan_t        plan_q;
	logic [PG_W-1:0]   want_q;
	logic [FILL_W-1:0] fill_i_q;

	// output register
	logic              m_tvalid_q;
	logic [ADDR_W-1:0] m_addr_q;
	logic              m_oom_q;
	logic              resp_load;

	// request decode
	logic              accept;
	opcode_t           op_in;
	logic [ADDR_W-1:0] size_in, rel_in;
	logic [CLS_W-1:0]  cls_in;
	logic              cls_ok_in;
	logic [ADDR_W-1:0] head_in;
	logic [31:0]       rel_pg;
	logic              pg_ok_in;

	// RAM ports
	logic               link_we;
	logic [LINK_AW-1:0] link_waddr, link_raddr;
	logic [ADDR_W-1:0]  link_wdata, link_rdata;
	logic               tag_we;
	logic [TW-1:0]      tag_waddr, tag_raddr;
	logic [CLS_W-1:0]   tag_rdata;

	// carving helpers
	logic [CW-1:0]     cls_idx, tag_idx;
	logic              tag_ok;
	logic              is_large;
	logic [PG_W-1:0]   want;
	grow_plan_t        plan;
	logic [31:0]       carve_full;
	logic [ADDR_W-1:0] carve_addr, carve_addr4;
	logic              carve_tag_ok;
	logic [ADDR_W:0]   off_cur, off_next;
	logic [ADDR_W-1:0] fill_a, fill_nxt;
	logic              fill_last;
	logic [PG_W:0]     grow_total;
	logic [PG_W-1:0]   cap;
	logic              fits;

	assign cfg_ready = 1'b1;

	assign op_in   = opcode_t'(s_tuser[0]);
	assign size_in = s_tdata[15:0];
	assign rel_in  = s_tdata[31:16];
	assign accept  = s_tvalid && s_tready;

	scfl_size_class #(.PAGE_BITS(PAGE_BITS)) u_size_class (
		.size (size_in),
		.cls  (cls_in)
	);

	assign cls_ok_in = ({1'b0, cls_in} < (CLS_W+1)'(NUM_CLASSES));
	assign head_in   = heads_q[cls_in[CW-1:0]];
	assign rel_pg    = 32'(rel_in) >> PAGE_BITS;
	assign pg_ok_in  = (rel_pg < 32'(MAX_PAGES));

	assign cls_idx = cls_q[CW-1:0];
	assign tag_idx = tag_rdata[CW-1:0];
	assign tag_ok  = ({1'b0, tag_rdata} < (CLS_W+1)'(NUM_CLASSES));

	// pages one refill of this class takes
	assign is_large = (cls_q > CLS_W'(PAGE_BITS));
	assign want     = is_large ? (PG_W'(1) << (cls_q - CLS_W'(PAGE_BITS))) : PG_W'(1);

	scfl_grow u_grow (
		.base_pages (base_pages_q),
		.grow_min   (grow_min_q),
		.grow_max   (grow_max_q),
		.grown      (grown_q),
		.spare      (spare_q),
		.want       (want),
		.plan       (plan)
	);

	assign cap        = (PG_W'(limit_pages_q) < PG_W'(PAGE_LIM)) ?
	                    PG_W'(limit_pages_q) : PG_W'(PAGE_LIM);
	assign grow_total = {1'b0, plan_q.cur} + {1'b0, plan_q.plus};
	assign fits       = (grow_total <= {1'b0, cap});

	assign carve_full   = 32'(carve_pg_q) << PAGE_BITS;
	assign carve_addr   = carve_full[ADDR_W-1:0];
	assign carve_addr4  = carve_addr + ADDR_W'(4);
	assign carve_tag_ok = (32'(carve_pg_q) < 32'(MAX_PAGES));

	// small class fill walk: one block per cycle
	assign off_cur   = (ADDR_W+1)'(fill_i_q) << cls_q;
	assign off_next  = ((ADDR_W+1)'(fill_i_q) + (ADDR_W+1)'(1)) << cls_q;
	assign fill_a    = carve_addr + off_cur[ADDR_W-1:0];
	assign fill_nxt  = carve_addr + off_next[ADDR_W-1:0];
	assign fill_last = (off_next == (ADDR_W+1)'(1 << PAGE_BITS));

	assign tag_waddr = TW'(carve_pg_q);
	assign tag_raddr = rel_pg[TW-1:0];

	// a response is loaded this cycle; it wins over draining the old one
	assign resp_load = ((state_q == ST_IDLE) && accept &&
	                    (((op_in == OP_ALLOC) && !cls_ok_in) ||
	                     ((op_in == OP_RELEASE) && !pg_ok_in))) ||
	                   (state_q == ST_POP) || (state_q == ST_REL) ||
	                   ((state_q == ST_COMMIT) && plan_q.need && !fits);

	scfl_ram #(.WIDTH(ADDR_W), .DEPTH(LINK_WORDS)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	scfl_ram #(.WIDTH(CLS_W), .DEPTH(MAX_PAGES)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_waddr),
		.wdata (cls_q),
		.raddr (tag_raddr),
		.rdata (tag_rdata)
	);

	// next state and RAM control
	always_comb begin
		state_d    = state_q;
		s_tready   = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
		link_we    = 1'b0;
		link_waddr = ptr_q[ADDR_W-1:2];
		link_wdata = '0;
		link_raddr = head_in[ADDR_W-1:2];
		tag_we     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op_in == OP_ALLOC) begin
						if (cls_ok_in) begin
							state_d = (head_in != '0) ? ST_POP : ST_GROW;
						end
					end else if (pg_ok_in) begin
						state_d = ST_REL;
					end
				end
			end
			ST_POP: begin
				state_d = ST_IDLE;
			end
			ST_REL: begin
				if (tag_ok) begin
					link_we    = 1'b1;
					link_wdata = heads_q[tag_idx];
				end
				state_d = ST_IDLE;
			end
			ST_GROW: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				state_d = (!plan_q.need || fits) ? ST_CARVE : ST_IDLE;
			end
			ST_CARVE: begin
				tag_we = carve_tag_ok;
				if (is_large) begin
					link_we    = 1'b1;
					link_waddr = carve_addr4[ADDR_W-1:2];
					state_d    = ST_POPRD;
				end else begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				link_we    = 1'b1;
				link_waddr = fill_a[ADDR_W-1:2];
				link_wdata = fill_last ? '0 : fill_nxt;
				if (fill_last) begin
					state_d = ST_POPRD;
				end
			end
			ST_POPRD: begin
				link_raddr = heads_q[cls_idx][ADDR_W-1:2];
				state_d    = ST_POP;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath and allocator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_pages_q  <= CFG_W'(1);
			limit_pages_q <= CFG_W'(64);
			grow_min_q    <= CFG_W'(32);
			grow_max_q    <= CFG_W'(64);
			for (int i = 0; i < NUM_CLASSES; i++) begin
				heads_q[i] <= '0;
			end
			spare_q    <= '0;
			carve_pg_q <= '0;
			grown_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_BASE_PAGES:  base_pages_q  <= cfg_data;
					CFG_LIMIT_PAGES: limit_pages_q <= cfg_data;
					CFG_GROW_MIN:    grow_min_q    <= cfg_data;
					CFG_GROW_MAX:    grow_max_q    <= cfg_data;
					default: ;
				endcase
			end

			if (m_tvalid_q && m_tready && !resp_load) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cls_q <= cls_in;
						ptr_q <= (op_in == OP_ALLOC) ? head_in : rel_in;
						if (op_in == OP_ALLOC && !cls_ok_in) begin
							m_tvalid_q <= 1'b1;
							m_addr_q   <= '0;
							m_oom_q    <= 1'b1;
						end else if (op_in == OP_RELEASE && !pg_ok_in) begin
							m_tvalid_q <= 1'b1;
							m_addr_q   <= '0;
							m_oom_q    <= 1'b0;
						end
					end
				end
				ST_POP: begin
					heads_q[cls_idx] <= link_rdata;
					m_tvalid_q       <= 1'b1;
					m_addr_q         <= ptr_q;
					m_oom_q          <= 1'b0;
				end
				ST_REL: begin
					if (tag_ok) begin
						heads_q[tag_idx] <= ptr_q;
					end
					m_tvalid_q <= 1'b1;
					m_addr_q   <= '0;
					m_oom_q    <= 1'b0;
				end
				ST_GROW: begin
					plan_q <= plan;
					want_q <= want;
				end
				ST_COMMIT: begin
					if (plan_q.need) begin
						if (fits) begin
							if (spare_q == '0) begin
								carve_pg_q <= plan_q.cur;
							end
							grown_q <= grown_q + plan_q.plus;
							spare_q <= spare_q + plan_q.plus;
						end else begin
							m_tvalid_q <= 1'b1;
							m_addr_q   <= '0;
							m_oom_q    <= 1'b1;
						end
					end
				end
				ST_CARVE: begin
					fill_i_q <= '0;
					if (is_large) begin
						heads_q[cls_idx] <= carve_addr4;
						carve_pg_q       <= carve_pg_q + want_q;
						spare_q          <= spare_q - want_q;
					end
				end
				ST_FILL: begin
					fill_i_q <= fill_i_q + FILL_W'(1);
					if (fill_last) begin
						heads_q[cls_idx] <= carve_addr;
						carve_pg_q       <= carve_pg_q + PG_W'(1);
						spare_q          <= spare_q - PG_W'(1);
					end
				end
				ST_POPRD: begin
					ptr_q <= heads_q[cls_idx];
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_addr_q;
	assign m_tuser  = m_oom_q;

endmodule

`default_nettype wire

>>> hw/rtl/scfl_ram.sv
// ----------------------------------------------------------------------------
// scfl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module scfl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> hw/rtl/scfl_size_class.sv
// ----------------------------------------------------------------------------
// scfl_size_class
// Maps a request size to its power-of-two class code.
// ----------------------------------------------------------------------------
`default_nettype none

module scfl_size_class #(
	parameter int PAGE_BITS = 10
) (
	input  wire logic [scfl_pkg::ADDR_W-1:0] size,
	output logic      [scfl_pkg::CLS_W-1:0]  cls
);
	import scfl_pkg::*;

	localparam logic [ADDR_W:0] THRESH = (ADDR_W+1)'((1 << PAGE_BITS) - 1);

	logic [ADDR_W:0]  s;
	logic [CLS_W-1:0] blen;

	// requests of at least (1 << PAGE_BITS) - 1 bytes carry a 4-byte header
	assign s = ({1'b0, size} >= THRESH) ? ({1'b0, size} + (ADDR_W+1)'(4)) : {1'b0, size};

	always_comb begin
		blen = '0;
		for (int i = 0; i <= ADDR_W; i++) begin
			if (s[i]) begin
				blen = CLS_W'(i + 1);
			end
		end
	end

	assign cls = (blen < CLS_W'(3)) ? CLS_W'(3) : blen;

endmodule

`default_nettype wire

>>> hw/rtl/scfl_grow.sv
// ----------------------------------------------------------------------------
// scfl_grow
// Works out whether the spare pool must grow and by how many pages.
// ----------------------------------------------------------------------------
`default_nettype none

module scfl_grow (
	input  wire logic [scfl_pkg::CFG_W-1:0] base_pages,
	input  wire logic [scfl_pkg::CFG_W-1:0] grow_min,
	input  wire logic [scfl_pkg::CFG_W-1:0] grow_max,
	input  wire logic [scfl_pkg::PG_W-1:0]  grown,
	input  wire logic [scfl_pkg::PG_W-1:0]  spare,
	input  wire logic [scfl_pkg::PG_W-1:0]  want,
	output scfl_pkg::grow_plan_t            plan
);
	import scfl_pkg::*;

	logic [PG_W-1:0] base_eff;
	logic [PG_W-1:0] cur;
	logic [PG_W-1:0] short;
	logic [PG_W-1:0] plus;

	assign base_eff = (base_pages == '0) ? PG_W'(1) : PG_W'(base_pages);
	assign cur      = base_eff + grown;
	assign short    = want - spare;

	always_comb begin
		plus = cur;
		if (plus < PG_W'(grow_min)) begin
			plus = PG_W'(grow_min);
		end
		if (plus > PG_W'(grow_max)) begin
			plus = PG_W'(grow_max);
		end
		if (plus < short) begin
			plus = short;
		end
	end

	assign plan.need = (spare < want);
	assign plan.cur  = cur;
	assign plan.plus = plus;

endmodule

`default_nettype wire
